// ===== hdl/kpsh_pkg.sv =====
package kpsh_pkg;

    // field widths of the stream and config beats
    localparam int CFG_W    = 6;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 10;
    localparam int LEN_W    = 11;
    localparam int QROW_W   = 5;
    localparam int BIN_W    = 4;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;

    localparam int NUM_BINS = 16;

    // longest read that still gets windows
    localparam int MAX_READ_LEN = 1024;

    localparam int DEF_MAX_WINDOW = 32;
    localparam int DEF_COUNT_BITS = 32;

    localparam logic MODE_COUNT = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SKIP   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADREF = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } base_t;

    // a=0 c=1 g=2 t=3, either case
    function automatic base_t decode_base(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] lc;
        base_t             b;
        lc = ch | 8'h20;
        b.ok   = 1'b1;
        b.code = 2'd0;
        unique case (lc)
            8'h61:   b.code = 2'd0;
            8'h63:   b.code = 2'd1;
            8'h67:   b.code = 2'd2;
            8'h74:   b.code = 2'd3;
            default: b.ok   = 1'b0;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/kmer_position_substitution_histogram.sv =====
// an accepted beat is registered in stage a, then in the output register on m_tdata;
// one beat per cycle while m_tready is high; each row's counter memory is read on
// accept and written back on output load, the last write-back forwarded. reset:
// window_length clears to 0; after rst_n rises a clearing pass zeroes all counters,
// with s_tready low until it ends (cfg writes are taken throughout)
module kmer_position_substitution_histogram #(
    parameter int MAX_WINDOW = kpsh_pkg::DEF_MAX_WINDOW,
    parameter int COUNT_BITS = kpsh_pkg::DEF_COUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kpsh_pkg::CFG_W-1:0]    cfg_data,    // window_length

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // ref_char, read_char, base_position, read_length, query_row, query_bin, zero pad
    input  logic [kpsh_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,     // mode

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, counter_value, zero pad
    output logic [kpsh_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int ROW_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int BIN_W = kpsh_pkg::BIN_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // window length register
    logic [kpsh_pkg::CFG_W-1:0] window_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else if (cfg_valid && cfg_ready)
            window_reg <= cfg_data;
    end

    // clearing pass
    logic             clr_active_reg;
    logic [BIN_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == BIN_W'(kpsh_pkg::NUM_BINS - 1))
                clr_active_reg <= 1'b0;
        end
    end

    // input beat fields
    logic [kpsh_pkg::CHAR_W-1:0] in_ref;
    logic [kpsh_pkg::CHAR_W-1:0] in_read;
    logic [kpsh_pkg::POS_W-1:0]  in_pos;
    logic [kpsh_pkg::LEN_W-1:0]  in_len;
    logic [kpsh_pkg::QROW_W-1:0] in_qrow;
    logic [BIN_W-1:0]            in_qbin;
    kpsh_pkg::base_t             in_rb;
    kpsh_pkg::base_t             in_qb;
    logic [BIN_W-1:0]            in_addr;

    assign in_ref  = s_tdata[7:0];
    assign in_read = s_tdata[15:8];
    assign in_pos  = s_tdata[25:16];
    assign in_len  = s_tdata[36:26];
    assign in_qrow = s_tdata[41:37];
    assign in_qbin = s_tdata[45:42];
    assign in_rb   = kpsh_pkg::decode_base(in_ref);
    assign in_qb   = kpsh_pkg::decode_base(in_read);
    assign in_addr = (s_tuser[0] == kpsh_pkg::MODE_READ) ? in_qbin : {in_rb.code, in_qb.code};

    // handshake
    logic a_valid_reg;
    logic o_valid_reg;
    logic o_load;
    logic accept;

    assign o_load   = a_valid_reg && (!o_valid_reg || m_tready);
    assign s_tready = (!a_valid_reg || o_load) && !clr_active_reg;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                a_valid_reg <= 1'b1;
            else if (o_load)
                a_valid_reg <= 1'b0;

            if (o_load)
                o_valid_reg <= 1'b1;
            else if (m_tready)
                o_valid_reg <= 1'b0;
        end
    end

    // stage a item registers
    logic                        a_mode_reg;
    logic                        a_ref_ok_reg;
    logic                        a_read_ok_reg;
    logic [kpsh_pkg::POS_W-1:0]  a_pos_reg;
    logic [kpsh_pkg::LEN_W-1:0]  a_len_reg;
    logic [kpsh_pkg::QROW_W-1:0] a_qrow_reg;
    logic [BIN_W-1:0]            a_addr_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_mode_reg    <= s_tuser[0];
            a_ref_ok_reg  <= in_rb.ok;
            a_read_ok_reg <= in_qb.ok;
            a_pos_reg     <= in_pos;
            a_len_reg     <= in_len;
            a_qrow_reg    <= in_qrow;
            a_addr_reg    <= in_addr;
        end
    end

    // whole-item window checks
    logic count_ok;

    assign count_ok = (a_mode_reg == kpsh_pkg::MODE_COUNT) && a_read_ok_reg && a_ref_ok_reg
                      && (window_reg != '0)
                      && (7'(window_reg) <= 7'(MAX_WINDOW))
                      && (17'(a_len_reg) <= 17'(kpsh_pkg::MAX_READ_LEN))
                      && (a_len_reg >= 11'(window_reg))
                      && (11'(a_pos_reg) < a_len_reg);

    // per-row counter memories, write-back forwarding
    logic [COUNT_BITS-1:0] cur_val [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] wr_en;
    logic [MAX_WINDOW-1:0] fw_valid_reg;
    logic [BIN_W-1:0]      fw_bin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fw_valid_reg <= '0;
        else if (o_load)
            fw_valid_reg <= wr_en;
    end

    always_ff @(posedge clk)
    begin
        if (o_load)
            fw_bin_reg <= a_addr_reg;
    end

    for (genvar j = 0; j < MAX_WINDOW; j++)
    begin : g_row
        logic [COUNT_BITS-1:0] mem [kpsh_pkg::NUM_BINS];
        logic [COUNT_BITS-1:0] rd_reg;
        logic [COUNT_BITS-1:0] fw_data_reg;
        logic [COUNT_BITS-1:0] inc_val;

        // window start pos - j must lie in [0, len - k]
        assign wr_en[j] = count_ok
                          && (7'(j) < 7'(window_reg))
                          && (11'(j) <= 11'(a_pos_reg))
                          && (12'(a_pos_reg) + 12'(window_reg) <= 12'(a_len_reg) + 12'(j));

        assign cur_val[j] = (fw_valid_reg[j] && (fw_bin_reg == a_addr_reg)) ? fw_data_reg
                                                                           : rd_reg;
        assign inc_val    = (cur_val[j] == COUNT_MAX) ? cur_val[j] : cur_val[j] + 1'b1;

        always_ff @(posedge clk)
        begin
            if (clr_active_reg)
                mem[clr_addr_reg] <= '0;
            else if (o_load && wr_en[j])
                mem[a_addr_reg] <= inc_val;
        end

        always_ff @(posedge clk)
        begin
            if (accept)
                rd_reg <= mem[in_addr];
        end

        always_ff @(posedge clk)
        begin
            if (o_load && wr_en[j])
                fw_data_reg <= inc_val;
        end
    end

    // result
    logic [6:0]                    qrow_ext;
    logic                          row_ok;
    logic [ROW_W-1:0]              row_sel;
    logic [63:0]                   sel_wide;
    logic [kpsh_pkg::STATUS_W-1:0] a_status;
    logic [kpsh_pkg::VALUE_W-1:0]  a_value;

    assign qrow_ext = 7'(a_qrow_reg);
    assign row_ok   = qrow_ext < 7'(MAX_WINDOW);
    assign row_sel  = ROW_W'(qrow_ext);
    assign sel_wide = row_ok ? 64'(cur_val[row_sel]) : '0;

    always_comb
    begin
        a_value = '0;
        priority if (a_mode_reg == kpsh_pkg::MODE_READ)
        begin
            a_status = kpsh_pkg::STATUS_OK;
            a_value  = sel_wide[31:0];
        end
        else if (!a_read_ok_reg)
            a_status = kpsh_pkg::STATUS_SKIP;
        else if (!a_ref_ok_reg)
            a_status = kpsh_pkg::STATUS_BADREF;
        else
            a_status = kpsh_pkg::STATUS_OK;
    end

    logic [kpsh_pkg::STATUS_W-1:0] o_status_reg;
    logic [kpsh_pkg::VALUE_W-1:0]  o_value_reg;

    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            o_status_reg <= a_status;
            o_value_reg  <= a_value;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {6'b0, o_value_reg, o_status_reg};

endmodule
